// ----- hw/rtl/iclt_pkg.sv -----
// package with shared constants for the idle connection lru timeout block
`default_nettype none
package iclt_pkg;
    localparam int MAX_CONNS = 32;
    localparam int TIME_BITS = 48;
    localparam int SLOT_W    = 5;
    localparam int CNT_W     = 6;
    localparam int LIMIT_W   = 48;

    localparam logic [1:0] OP_CONNECT = 2'd0;
    localparam logic [1:0] OP_MESSAGE = 2'd1;
    localparam logic [1:0] OP_DISCON  = 2'd2;
    localparam logic [1:0] OP_TICK    = 2'd3;

    localparam logic KIND_CLOSE  = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10000000);
endpackage
`default_nettype wire

// ----- hw/rtl/iclt_ram.sv -----
// generic simple dual port ram (one write port, one read port) with registered read
`default_nettype none
module iclt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/idle_connection_lru_timeout_core.sv -----
// top level of the idle connection lru timeout block
//
// channel   | direction | handshake            | payload
// config    | in        | i_cfg_we             | i_cfg_wdata (idle limit)
// event     | in        | i_start, o_busy      | i_operation, i_conn_slot, i_now_time
// result    | out       | o_valid strobe       | o_result_kind, o_target_slot, o_last_of_run
//
// states after the accepting edge: connect decode, append; reject decode (strobe next);
// message decode, unlink, append; disconnect decode, unlink (a read, then two writes);
// ignored message or disconnect decode; tick decode, then read, wait, compare per entry
// and output: the single read port of the stamp, next and prev memories sets the pace
// the time compare goes through one shared subtractor
// reset is synchronous; link and stamp memories need no clearing
// results cannot be stalled, each is shown for one cycle
`default_nettype none
module idle_connection_lru_timeout_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [iclt_pkg::LIMIT_W-1:0]    i_cfg_wdata,
    input  wire logic                            i_start,
    output logic                                 o_busy,
    input  wire logic [1:0]                      i_operation,
    input  wire logic [iclt_pkg::SLOT_W-1:0]     i_conn_slot,
    input  wire logic [iclt_pkg::TIME_BITS-1:0]  i_now_time,
    output logic                                 o_valid,
    output logic                                 o_result_kind,
    output logic [iclt_pkg::SLOT_W-1:0]          o_target_slot,
    output logic                                 o_last_of_run
);
    import iclt_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_UL_RD  = 4'd2;  // read prev and next of slot
    localparam logic [3:0] S_UL_W1  = 4'd3;  // patch next of prev
    localparam logic [3:0] S_UL_W2  = 4'd4;  // patch prev of next
    localparam logic [3:0] S_APPEND = 4'd5;
    localparam logic [3:0] S_T_RD   = 4'd6;  // issue reads for cur
    localparam logic [3:0] S_T_WAIT = 4'd7;
    localparam logic [3:0] S_T_CMP  = 4'd8;
    localparam logic [3:0] S_T_OUT  = 4'd9;

    logic [3:0]           r_state, n_state;
    logic [LIMIT_W-1:0]   r_limit;
    logic [MAX_CONNS-1:0] r_listed, n_listed;
    logic [SLOT_W-1:0]    r_head, n_head, r_tail, n_tail;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [1:0]           r_op, n_op;
    logic [SLOT_W-1:0]    r_slot, n_slot;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [SLOT_W-1:0]    r_cur, n_cur;
    logic [CNT_W-1:0]     r_left, n_left;
    logic [CNT_W-1:0]     r_nres, n_nres;
    logic                 r_pend, n_pend;       // close request held for output
    logic [SLOT_W-1:0]    r_pslot, n_pslot;
    logic                 r_append, n_append;   // message appends after unlink
    logic [SLOT_W-1:0]    r_pv, n_pv, r_nx, n_nx;
    logic                 r_ov, n_ov, r_okind, n_okind, r_olast, n_olast;
    logic [SLOT_W-1:0]    r_oslot, n_oslot;

    // memory ports
    logic                 nx_we, pv_we, tm_we;
    logic [SLOT_W-1:0]    nx_wa, pv_wa, tm_wa, nx_wd, pv_wd, rd_a;
    logic [TIME_BITS-1:0] tm_wd, tm_rd;
    logic [SLOT_W-1:0]    nx_rd, pv_rd;

    iclt_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_CONNS)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(rd_a), .o_rdata(nx_rd));
    iclt_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_CONNS)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(rd_a), .o_rdata(pv_rd));
    iclt_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_CONNS)) u_time (
        .i_clk(i_clk), .i_we(tm_we), .i_waddr(tm_wa), .i_wdata(tm_wd),
        .i_raddr(rd_a), .o_rdata(tm_rd));

    // shared subtractor: now minus stamp, borrow marks a time jump
    logic [TIME_BITS:0] age;
    logic               jump, stale;
    assign age   = {1'b0, r_now} - {1'b0, tm_rd};
    assign jump  = age[TIME_BITS];
    assign stale = !jump && ({{(LIMIT_W+1){1'b0}}, age[TIME_BITS-1:0]}
                   > {{(TIME_BITS+1){1'b0}}, r_limit});

    assign o_busy        = (r_state != S_IDLE);
    assign o_valid       = r_ov;
    assign o_result_kind = r_okind;
    assign o_target_slot = r_oslot;
    assign o_last_of_run = r_olast;

    always_comb begin
        n_state = r_state; n_listed = r_listed; n_head = r_head; n_tail = r_tail;
        n_count = r_count; n_op = r_op; n_slot = r_slot; n_now = r_now;
        n_cur = r_cur; n_left = r_left; n_nres = r_nres; n_pend = r_pend;
        n_pslot = r_pslot; n_append = r_append; n_pv = r_pv; n_nx = r_nx;
        n_ov = 1'b0; n_okind = r_okind; n_oslot = r_oslot; n_olast = r_olast;
        nx_we = 1'b0; pv_we = 1'b0; tm_we = 1'b0;
        nx_wa = r_slot; pv_wa = r_slot; tm_wa = r_slot;
        nx_wd = r_slot; pv_wd = r_tail; tm_wd = r_now;
        rd_a  = r_slot;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op = i_operation; n_slot = i_conn_slot; n_now = i_now_time;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_IDLE;
                case (r_op)
                    OP_CONNECT: begin
                        if (r_listed[r_slot]) begin
                            n_ov = 1'b1; n_okind = KIND_REJECT;
                            n_oslot = r_slot; n_olast = 1'b1;
                        end else begin
                            n_state = S_APPEND;
                        end
                    end
                    OP_MESSAGE, OP_DISCON: begin
                        if (r_listed[r_slot]) begin
                            n_append = (r_op == OP_MESSAGE);
                            n_state = S_UL_RD;
                        end
                    end
                    default: begin
                        n_cur = r_head; n_left = r_count; n_nres = '0;
                        n_pend = 1'b0; n_state = S_T_RD;
                    end
                endcase
            end
            S_UL_RD: begin
                n_state = S_UL_W1;
            end
            S_UL_W1: begin
                n_pv = pv_rd; n_nx = nx_rd;
                if (r_head == r_slot) begin
                    n_head = nx_rd;
                end else begin
                    nx_we = 1'b1; nx_wa = pv_rd; nx_wd = nx_rd;
                end
                n_state = S_UL_W2;
            end
            S_UL_W2: begin
                if (r_tail == r_slot) begin
                    n_tail = r_pv;
                end else begin
                    pv_we = 1'b1; pv_wa = r_nx; pv_wd = r_pv;
                end
                n_listed[r_slot] = 1'b0;
                n_count = r_count - CNT_W'(1);
                n_state = r_append ? S_APPEND : S_IDLE;
            end
            S_APPEND: begin
                tm_we = 1'b1;
                if (r_count == '0) begin
                    n_head = r_slot;
                end else begin
                    nx_we = 1'b1; nx_wa = r_tail; nx_wd = r_slot;
                    pv_we = 1'b1; pv_wa = r_slot; pv_wd = r_tail;
                end
                n_tail = r_slot;
                n_listed[r_slot] = 1'b1;
                n_count = r_count + CNT_W'(1);
                n_state = S_IDLE;
            end
            S_T_RD: begin
                rd_a = r_cur;
                if (r_left == '0 || r_nres == CNT_W'(MAX_CONNS)) begin
                    n_state = S_T_OUT;
                end else begin
                    n_state = S_T_WAIT;
                end
            end
            S_T_WAIT: begin
                rd_a = r_cur;
                n_state = S_T_CMP;
            end
            S_T_CMP: begin
                rd_a = r_cur;
                n_state = S_T_RD;
                if (jump) begin
                    tm_we = 1'b1; tm_wa = r_cur; tm_wd = r_now;
                end else if (stale) begin
                    // emit held result, hold this one so the last can be flagged
                    if (r_pend) begin
                        n_ov = 1'b1; n_okind = KIND_CLOSE;
                        n_oslot = r_pslot; n_olast = 1'b0;
                    end
                    n_pend = 1'b1; n_pslot = r_cur;
                    n_nres = r_nres + CNT_W'(1);
                end else begin
                    n_state = S_T_OUT;
                end
                n_left = r_left - CNT_W'(1);
                n_cur = nx_rd;
            end
            S_T_OUT: begin
                if (r_pend) begin
                    n_ov = 1'b1; n_okind = KIND_CLOSE;
                    n_oslot = r_pslot; n_olast = 1'b1;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_limit <= LIMIT_RESET; r_listed <= '0;
            r_head <= '0; r_tail <= '0; r_count <= '0; r_ov <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_state <= n_state; r_listed <= n_listed; r_head <= n_head;
            r_tail <= n_tail; r_count <= n_count; r_ov <= n_ov; r_pend <= n_pend;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
        r_op <= n_op; r_slot <= n_slot; r_now <= n_now; r_cur <= n_cur;
        r_left <= n_left; r_nres <= n_nres; r_pslot <= n_pslot;
        r_append <= n_append; r_pv <= n_pv; r_nx <= n_nx;
        r_okind <= n_okind; r_oslot <= n_oslot; r_olast <= n_olast;
    end
endmodule
`default_nettype wire

// ----- tb/sv/idle_connection_lru_timeout_core_tb.sv -----
// testbench for the idle connection lru timeout block: directed and random events vs a predictor
`timescale 1ns / 1ps
`default_nettype none

// scoreboard: owns the lru list predictor and the queue of expected results
class lru_timeout_scoreboard;
    typedef struct packed {
        logic       kind;
        logic [4:0] slot;
        logic       last;
    } close_result_t;

    logic [4:0]  nxt [32];
    logic [4:0]  prv [32];
    logic [47:0] stamp [32];
    bit          listed [32];
    logic [4:0]  head, tail;
    int          count;
    logic [47:0] idle_limit;
    close_result_t pending [$];
    int          mismatches;

    function new();
        for (int i = 0; i < 32; i++) begin
            nxt[i] = '0; prv[i] = '0; stamp[i] = '0; listed[i] = 0;
        end
        head = '0; tail = '0; count = 0;
        idle_limit = iclt_pkg::LIMIT_RESET;
        mismatches = 0;
    endfunction

    function void append_slot(logic [4:0] s);
        if (count == 0) begin
            head = s;
        end else begin
            nxt[tail] = s;
            prv[s] = tail;
        end
        tail = s;
        listed[s] = 1;
        count++;
    endfunction

    function void unlink_slot(logic [4:0] s);
        if (head == s) begin
            head = nxt[s];
        end else begin
            nxt[prv[s]] = nxt[s];
        end
        if (tail == s) begin
            tail = prv[s];
        end else begin
            prv[nxt[s]] = prv[s];
        end
        listed[s] = 0;
        if (count > 0) count--;
    endfunction

    // note an accepted event transaction and queue its results
    function void note_event(logic [1:0] op, logic [4:0] s, logic [47:0] now);
        close_result_t r;
        logic [4:0] cur;
        int left;
        int n;
        n = 0;
        case (op)
            iclt_pkg::OP_CONNECT: begin
                if (listed[s]) begin
                    r.kind = iclt_pkg::KIND_REJECT; r.slot = s; r.last = 1'b1;
                    pending = {pending, r};
                end else begin
                    stamp[s] = now;
                    append_slot(s);
                end
            end
            iclt_pkg::OP_MESSAGE: begin
                if (listed[s]) begin
                    stamp[s] = now;
                    unlink_slot(s);
                    append_slot(s);
                end
            end
            iclt_pkg::OP_DISCON: begin
                if (listed[s]) unlink_slot(s);
            end
            default: begin
                // walk from the least recently active entry
                cur = head;
                left = count;
                while (left > 0 && n < 32) begin
                    if (now < stamp[cur]) begin
                        stamp[cur] = now;
                    end else if (now - stamp[cur] > idle_limit) begin
                        r.kind = iclt_pkg::KIND_CLOSE; r.slot = cur; r.last = 1'b0;
                        pending = {pending, r};
                        n++;
                    end else begin
                        break;
                    end
                    left--;
                    cur = nxt[cur];
                end
                if (n > 0) pending[$].last = 1'b1;
            end
        endcase
    endfunction

    function void check_result(logic kind, logic [4:0] s, logic last);
        close_result_t e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result kind=%0d slot=%0d last=%0d", kind, s, last);
            return;
        end
        e = pending.pop_front();
        if (e.kind !== kind || e.slot !== s || e.last !== last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: expected kind=%0d slot=%0d last=%0d, got %0d %0d %0d",
                         e.kind, e.slot, e.last, kind, s, last);
        end
    endfunction
endclass

module idle_connection_lru_timeout_core_tb;
    import iclt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [LIMIT_W-1:0]   i_cfg_wdata;
    logic                 i_start;
    logic                 o_busy;
    logic [1:0]           i_operation;
    logic [SLOT_W-1:0]    i_conn_slot;
    logic [TIME_BITS-1:0] i_now_time;
    logic                 o_valid;
    logic                 o_result_kind;
    logic [SLOT_W-1:0]    o_target_slot;
    logic                 o_last_of_run;

    lru_timeout_scoreboard sb;
    int          idle_pct;
    int          stall_cycles;
    logic [47:0] clock_us;

    idle_connection_lru_timeout_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_operation  (i_operation),
        .i_conn_slot  (i_conn_slot),
        .i_now_time   (i_now_time),
        .o_valid      (o_valid),
        .o_result_kind(o_result_kind),
        .o_target_slot(o_target_slot),
        .o_last_of_run(o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // results are sampled at the edge that ends their strobe cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_result_kind, o_target_slot, o_last_of_run);
    end

    // watchdog: cycles with no accepted transaction of either kind
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // send one event transaction, idling beforehand at the current rate
    // the block is always busy in the cycle after an accept, so the first edge costs nothing
    task automatic send_event(logic [1:0] op, logic [4:0] s, logic [47:0] now);
        @(posedge i_clk);
        while ($urandom_range(99, 0) < idle_pct) @(posedge i_clk);
        i_start     <= 1'b1;
        i_operation <= op;
        i_conn_slot <= s;
        i_now_time  <= now;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_event(op, s, now);
        i_start <= 1'b0;
    endtask

    // wait for the block to drain, then give a tick walk time to finish
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [47:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.idle_limit = v;
    endtask

    // advance the local clock, sometimes jumping backward or to a random value
    function automatic logic [47:0] next_time();
        int r;
        r = $urandom_range(99, 0);
        if (r < 8) clock_us = clock_us - 48'($urandom_range(5000, 1));
        else if (r < 12) clock_us = 48'({$urandom, $urandom});
        else clock_us = clock_us + 48'($urandom_range(4000, 0));
        return clock_us;
    endfunction

    task automatic random_phase(int n_items);
        logic [1:0] op;
        int r;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(99, 0);
            if (r < 35) op = OP_CONNECT;
            else if (r < 60) op = OP_MESSAGE;
            else if (r < 75) op = OP_DISCON;
            else op = OP_TICK;
            send_event(op, 5'($urandom_range(31, 0)), next_time());
        end
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_start = 1'b0;
        i_operation = OP_CONNECT;
        i_conn_slot = '0;
        i_now_time = '0;
        idle_pct = 0;
        clock_us = 48'd1000;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset limit, extremes of slot and time, rejects, ignores
        send_event(OP_TICK, 5'd0, 48'd0);
        send_event(OP_MESSAGE, 5'd31, 48'd5);
        send_event(OP_DISCON, 5'd0, 48'd5);
        send_event(OP_CONNECT, 5'd0, 48'd0);
        send_event(OP_CONNECT, 5'd31, 48'd100);
        send_event(OP_CONNECT, 5'd0, 48'd200);
        send_event(OP_TICK, 5'd0, 48'd10000101);
        send_event(OP_TICK, 5'd0, 48'd10000100);
        send_event(OP_MESSAGE, 5'd0, 48'hFFFF_FFFF_FFFF);
        send_event(OP_TICK, 5'd0, 48'd50);
        send_event(OP_TICK, 5'd0, 48'hFFFF_FFFF_FFFF);
        send_event(OP_DISCON, 5'd31, 48'd0);
        send_event(OP_DISCON, 5'd0, 48'd0);
        // fill the table so every slot is listed, then a full walk
        for (int s = 0; s < 32; s++) send_event(OP_CONNECT, 5'(s), 48'(s));
        send_event(OP_CONNECT, 5'd17, 48'd40);
        write_limit(48'd0);
        send_event(OP_TICK, 5'd21, 48'd100);
        write_limit(48'hFFFF_FFFF_FFFF);
        send_event(OP_TICK, 5'd10, 48'hFFFF_FFFF_FFFF);
        send_event(OP_TICK, 5'd0, 48'd0);
        for (int s = 0; s < 32; s++) send_event(OP_DISCON, 5'(s), 48'd0);

        // random phases with different limits and idling
        write_limit(48'd3000);
        idle_pct = 28;
        random_phase(45);
        write_limit(48'($urandom_range(20000, 0)));
        idle_pct = 84;
        random_phase(40);
        write_limit(48'd0);
        idle_pct = 0;
        random_phase(25);
        write_limit(48'd10000000);
        random_phase(20);

        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
hw/rtl/iclt_pkg.sv
hw/rtl/iclt_ram.sv
hw/rtl/idle_connection_lru_timeout_core.sv
tb/sv/idle_connection_lru_timeout_core_tb.sv
